>>> rtl/svgm_pkg.sv
// Shared types, constants and helper functions of the sphere voxel grid marker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package svgm_pkg;

  localparam int COORD_W    = 24;
  localparam int SPC_W      = 10;
  localparam int PRB_W      = 12;
  localparam int GN_W       = 7;
  localparam int REQ_W      = 2;
  localparam int RSQ_W      = 24;
  localparam int VIX_W      = 6;
  localparam int STATE_W    = 2;
  localparam int CNT_W      = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int NUM_W = 26;
  localparam int QUO_W = 25;
  localparam int OFS_W = 28;
  localparam int LIM_W = 26;
  localparam int SQ_W  = 14;
  localparam int BOX_W = 9;
  localparam int MUL_W = 12;

  localparam int DEF_MAX_N = 64;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CARVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

  localparam logic [STATE_W-1:0] VOX_EMPTY = 2'd0;
  localparam logic [STATE_W-1:0] VOX_OCC   = 2'd1;
  localparam logic [STATE_W-1:0] VOX_SURF  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NY  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NZ  = 3'd7;

  localparam logic [SPC_W-1:0] SPC_RST = 10'd128;
  localparam logic [PRB_W-1:0] PRB_RST = 12'd358;
  localparam logic [GN_W-1:0]  GN_RST  = 7'd64;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic [SPC_W-1:0]          spacing;
    logic [PRB_W-1:0]          probe;
    logic [BOX_W-1:0]          n_x;
    logic [BOX_W-1:0]          n_y;
    logic [BOX_W-1:0]          n_z;
  } svgm_cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]        req;
    logic                    box_empty;
    logic                    clip;
    logic [BOX_W-1:0]        lo_x;
    logic [BOX_W-1:0]        lo_y;
    logic [BOX_W-1:0]        lo_z;
    logic [BOX_W-1:0]        hi_x;
    logic [BOX_W-1:0]        hi_y;
    logic [BOX_W-1:0]        hi_z;
    logic signed [OFS_W-1:0] off_x;
    logic signed [OFS_W-1:0] off_y;
    logic signed [OFS_W-1:0] off_z;
    logic [LIM_W-1:0]        lim;
    logic [VIX_W-1:0]        vx;
    logic [VIX_W-1:0]        vy;
    logic [VIX_W-1:0]        vz;
  } svgm_job_t;

  typedef struct packed {
    logic [BOX_W-1:0] lo;
    logic [BOX_W-1:0] hi;
    logic             clip;
    logic             empty;
  } svgm_axis_t;

  // Clamps one axis of a sphere box, given the truncated quotients of both ends.
  function automatic svgm_axis_t axis_box(input logic [QUO_W-1:0] qa,
                                          input logic [QUO_W-1:0] qb,
                                          input logic [BOX_W-1:0] n);
    svgm_axis_t       r;
    logic [QUO_W-1:0] lo_w;
    logic [QUO_W-1:0] hi_w;
    logic [QUO_W-1:0] nw;
    nw      = QUO_W'(n);
    lo_w    = (qa == '0) ? QUO_W'(1) : qa;
    hi_w    = (qb > nw) ? nw : qb;
    r.clip  = (qa == '0) || (qb > nw);
    r.empty = lo_w > hi_w;
    r.lo    = lo_w[BOX_W-1:0];
    r.hi    = hi_w[BOX_W-1:0];
    return r;
  endfunction

  // Square of an offset, saturated where it lies far beyond any usable limit.
  function automatic logic [2*SQ_W-1:0] sat_sq(input logic signed [OFS_W-1:0] v);
    logic [OFS_W-1:0] a;
    logic [SQ_W-1:0]  m;
    a = v[OFS_W-1] ? OFS_W'(-v) : OFS_W'(v);
    m = (a[OFS_W-1:SQ_W] != '0) ? '1 : a[SQ_W-1:0];
    return (2*SQ_W)'(m) * (2*SQ_W)'(m);
  endfunction

endpackage

`default_nettype wire

>>> rtl/sphere_voxel_grid_marker_unit.sv
// Top level of the sphere voxel grid marker: configuration registers, front end,
// job queue and grid engine. Uses svgm_pkg, svgm_front, svgm_fifo and svgm_back.
`default_nettype none

// After reset the unit sweeps its voxel memory once, one entry per cycle
// (MAX_NX*MAX_NY*MAX_NZ rounded up to powers of two per axis, 262144 entries by
// default), and holds full high until that sweep ends. An add or carve word then
// passes through the front end, where one serial divider produces the six box
// bounds at one quotient bit per cycle, and then through the grid engine, whose
// voxel memory (one read port, one write port) visits one voxel of the clipped
// box per cycle. A clear word sweeps every memory entry, one per cycle; a read
// word reads a single entry. The two-entry queue lets the front end prepare the
// next word while the grid engine works on the last.
module sphere_voxel_grid_marker_unit import svgm_pkg::*; #(
  parameter int MAX_NX = DEF_MAX_N,
  parameter int MAX_NY = DEF_MAX_N,
  parameter int MAX_NZ = DEF_MAX_N
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [REQ_W-1:0]          req_type,
  input  wire logic signed [COORD_W-1:0] center_x,
  input  wire logic signed [COORD_W-1:0] center_y,
  input  wire logic signed [COORD_W-1:0] center_z,
  input  wire logic [PRB_W-1:0]          radius,
  input  wire logic [RSQ_W-1:0]          radius_sq,
  input  wire logic [VIX_W-1:0]          voxel_x,
  input  wire logic [VIX_W-1:0]          voxel_y,
  input  wire logic [VIX_W-1:0]          voxel_z,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [STATE_W-1:0]             voxel_state,
  output logic [CNT_W-1:0]               changed_count,
  output logic                           clipped,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
  logic [SPC_W-1:0]          grid_spacing;
  logic [PRB_W-1:0]          probe_radius;
  logic [GN_W-1:0]           grid_nx, grid_ny, grid_nz;

  svgm_cfg_t cfg;
  svgm_job_t fjob, bjob;
  logic      q_push, q_full, q_pop, q_empty, init_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
      grid_spacing <= SPC_RST;
      probe_radius <= PRB_RST;
      grid_nx      <= GN_RST;
      grid_ny      <= GN_RST;
      grid_nz      <= GN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_x     <= cfg_data;
        CFG_ORIGIN_Y: origin_y     <= cfg_data;
        CFG_ORIGIN_Z: origin_z     <= cfg_data;
        CFG_SPACING:  grid_spacing <= cfg_data[SPC_W-1:0];
        CFG_PROBE:    probe_radius <= cfg_data[PRB_W-1:0];
        CFG_GRID_NX:  grid_nx      <= cfg_data[GN_W-1:0];
        CFG_GRID_NY:  grid_ny      <= cfg_data[GN_W-1:0];
        CFG_GRID_NZ:  grid_nz      <= cfg_data[GN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.origin_x = origin_x;
    cfg.origin_y = origin_y;
    cfg.origin_z = origin_z;
    cfg.spacing  = (grid_spacing == '0) ? SPC_W'(1) : grid_spacing;
    cfg.probe    = probe_radius;
    cfg.n_x = (BOX_W'(grid_nx) > BOX_W'(MAX_NX)) ? BOX_W'(MAX_NX) : BOX_W'(grid_nx);
    cfg.n_y = (BOX_W'(grid_ny) > BOX_W'(MAX_NY)) ? BOX_W'(MAX_NY) : BOX_W'(grid_ny);
    cfg.n_z = (BOX_W'(grid_nz) > BOX_W'(MAX_NZ)) ? BOX_W'(MAX_NZ) : BOX_W'(grid_nz);
  end

  svgm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .radius    (radius),
    .radius_sq (radius_sq),
    .voxel_x   (voxel_x),
    .voxel_y   (voxel_y),
    .voxel_z   (voxel_z),
    .cfg       (cfg),
    .init_busy (init_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (fjob)
  );

  svgm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_job  (fjob),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_job  (bjob),
    .q_empty (q_empty)
  );

  svgm_back #(
    .MAX_NX (MAX_NX),
    .MAX_NY (MAX_NY),
    .MAX_NZ (MAX_NZ)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .job           (bjob),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .pop           (pop),
    .empty         (empty),
    .voxel_state   (voxel_state),
    .changed_count (changed_count),
    .clipped       (clipped)
  );

endmodule

`default_nettype wire

>>> rtl/svgm_front.sv
// Front end: takes request words, computes clipped sphere boxes with a serial
// divider and the starting center offsets, and queues a job. Uses svgm_pkg.
`default_nettype none

module svgm_front import svgm_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [REQ_W-1:0]          req_type,
  input  wire logic signed [COORD_W-1:0] center_x,
  input  wire logic signed [COORD_W-1:0] center_y,
  input  wire logic signed [COORD_W-1:0] center_z,
  input  wire logic [PRB_W-1:0]          radius,
  input  wire logic [RSQ_W-1:0]          radius_sq,
  input  wire logic [VIX_W-1:0]          voxel_x,
  input  wire logic [VIX_W-1:0]          voxel_y,
  input  wire logic [VIX_W-1:0]          voxel_z,
  input  svgm_cfg_t                      cfg,
  input  wire logic                      init_busy,
  input  wire logic                      q_full,
  output logic                           q_push,
  output svgm_job_t                      q_job
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_DLOAD = 3'd1;
  localparam logic [2:0] F_DIV   = 3'd2;
  localparam logic [2:0] F_MUL   = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [2:0]                fstate;
  logic [REQ_W-1:0]          it_req;
  logic signed [COORD_W-1:0] it_cx, it_cy, it_cz;
  logic [PRB_W-1:0]          it_r;
  logic [RSQ_W-1:0]          it_rsq;
  logic [VIX_W-1:0]          it_vx, it_vy, it_vz;
  logic [2:0]                dsel;
  logic [4:0]                dcnt;
  logic [SPC_W-1:0]          rem;
  logic [QUO_W-1:0]          dvd;
  logic [QUO_W-1:0]          quo [6];
  logic [2:0]                mstep;
  logic [2*MUL_W-1:0]        mul_p;
  logic signed [OFS_W-1:0]   off_x, off_y, off_z;
  logic [LIM_W-1:0]          lim;

  logic signed [COORD_W-1:0] dc, dorg;
  logic signed [NUM_W-1:0]   num;
  logic [SPC_W:0]            dtry;
  logic                      dge;
  logic [SPC_W-1:0]          rem_next;
  logic [QUO_W-1:0]          dvd_next;
  svgm_axis_t                bx, by, bz;
  logic [MUL_W-1:0]          mul_a, mul_b;
  logic signed [COORD_W-1:0] bc, borg;
  logic signed [OFS_W-1:0]   off_new;

  assign full = (fstate != F_IDLE) || init_busy;

  always_comb begin
    case (dsel[2:1])
      2'd0:    begin dc = it_cx; dorg = cfg.origin_x; end
      2'd1:    begin dc = it_cy; dorg = cfg.origin_y; end
      default: begin dc = it_cz; dorg = cfg.origin_z; end
    endcase
    num = NUM_W'(dc) - NUM_W'(dorg) + NUM_W'({1'b0, cfg.spacing})
        + (dsel[0] ? NUM_W'({1'b0, it_r}) : -NUM_W'({1'b0, it_r}));
  end

  always_comb begin
    dtry     = {rem, dvd[QUO_W-1]};
    dge      = dtry >= {1'b0, cfg.spacing};
    rem_next = dge ? SPC_W'(dtry - {1'b0, cfg.spacing}) : dtry[SPC_W-1:0];
    dvd_next = {dvd[QUO_W-2:0], dge};
  end

  assign bx = axis_box(quo[0], quo[1], cfg.n_x);
  assign by = axis_box(quo[2], quo[3], cfg.n_y);
  assign bz = axis_box(quo[4], quo[5], cfg.n_z);

  always_comb begin
    case (mstep)
      3'd0: begin
        mul_a = MUL_W'(cfg.spacing);
        mul_b = MUL_W'({bx.lo, 1'b0}) - MUL_W'(1);
      end
      3'd1: begin
        mul_a = MUL_W'(cfg.spacing);
        mul_b = MUL_W'({by.lo, 1'b0}) - MUL_W'(1);
      end
      3'd2: begin
        mul_a = MUL_W'(cfg.spacing);
        mul_b = MUL_W'({bz.lo, 1'b0}) - MUL_W'(1)
              + ((it_req == REQ_CARVE) ? MUL_W'(2) : MUL_W'(0));
      end
      default: begin
        mul_a = cfg.probe;
        mul_b = cfg.probe;
      end
    endcase
  end

  always_comb begin
    case (mstep)
      3'd1:    begin bc = it_cx; borg = cfg.origin_x; end
      3'd2:    begin bc = it_cy; borg = cfg.origin_y; end
      default: begin bc = it_cz; borg = cfg.origin_z; end
    endcase
    off_new = OFS_W'(mul_p) + ((OFS_W'(borg) - OFS_W'(bc)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      unique case (fstate)
        F_IDLE: begin
          if (push && !full) begin
            if (req_type == REQ_ADD || req_type == REQ_CARVE) begin
              fstate <= F_DLOAD;
            end else begin
              fstate <= F_PUSH;
            end
          end
        end
        F_DLOAD: fstate <= F_DIV;
        F_DIV: begin
          if (dcnt == 5'(QUO_W - 1) && dsel == 3'd5) begin
            fstate <= F_MUL;
          end else if (dcnt == 5'(QUO_W - 1)) begin
            fstate <= F_DLOAD;
          end
        end
        F_MUL: begin
          if (mstep == 3'd4) begin
            fstate <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            fstate <= F_IDLE;
          end
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (fstate)
      F_IDLE: begin
        it_req <= req_type;
        it_cx  <= center_x;
        it_cy  <= center_y;
        it_cz  <= center_z;
        it_r   <= (req_type == REQ_CARVE) ? cfg.probe : radius;
        it_rsq <= radius_sq;
        it_vx  <= voxel_x;
        it_vy  <= voxel_y;
        it_vz  <= voxel_z;
        dsel   <= '0;
        mstep  <= '0;
      end
      F_DLOAD: begin
        rem  <= '0;
        dcnt <= '0;
        dvd  <= (num > 0) ? num[QUO_W-1:0] : '0;
      end
      F_DIV: begin
        rem  <= rem_next;
        dvd  <= dvd_next;
        dcnt <= dcnt + 5'd1;
        if (dcnt == 5'(QUO_W - 1)) begin
          quo[dsel] <= dvd_next;
          dsel      <= dsel + 3'd1;
        end
      end
      F_MUL: begin
        mul_p <= mul_a * mul_b;
        mstep <= mstep + 3'd1;
        case (mstep)
          3'd1: off_x <= off_new;
          3'd2: off_y <= off_new;
          3'd3: off_z <= off_new;
          3'd4: lim <= (it_req == REQ_CARVE) ? {mul_p, 2'b00} : {it_rsq, 2'b00};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    q_push          = (fstate == F_PUSH) && !q_full;
    q_job.req       = it_req;
    q_job.box_empty = bx.empty || by.empty || bz.empty;
    q_job.clip      = bx.clip || by.clip || bz.clip;
    q_job.lo_x      = bx.lo;
    q_job.lo_y      = by.lo;
    q_job.lo_z      = bz.lo;
    q_job.hi_x      = bx.hi;
    q_job.hi_y      = by.hi;
    q_job.hi_z      = bz.hi;
    q_job.off_x     = off_x;
    q_job.off_y     = off_y;
    q_job.off_z     = off_z;
    q_job.lim       = lim;
    q_job.vx        = it_vx;
    q_job.vy        = it_vy;
    q_job.vz        = it_vz;
  end

endmodule

`default_nettype wire

>>> rtl/svgm_fifo.sv
// Two-entry job queue between the front end and the grid engine.
// Uses svgm_pkg for the job word.
`default_nettype none

module svgm_fifo import svgm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  svgm_job_t wr_job,
  output logic      q_full,
  input  wire logic rd,
  output svgm_job_t rd_job,
  output logic      q_empty
);

  svgm_job_t  slot [2];
  logic       wptr, rptr;
  logic [1:0] fill;

  assign q_full  = fill == 2'd2;
  assign q_empty = fill == 2'd0;
  assign rd_job  = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (wr) begin
        wptr <= !wptr;
      end
      if (rd) begin
        rptr <= !rptr;
      end
      fill <= fill + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wptr] <= wr_job;
    end
  end

endmodule

`default_nettype wire

>>> rtl/svgm_back.sv
// Grid engine: holds the voxel memory, walks sphere boxes one voxel a cycle,
// sweeps the memory for clears and reset, and holds the result word. Uses svgm_pkg.
`default_nettype none

module svgm_back import svgm_pkg::*; #(
  parameter int MAX_NX = DEF_MAX_N,
  parameter int MAX_NY = DEF_MAX_N,
  parameter int MAX_NZ = DEF_MAX_N
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  svgm_cfg_t          cfg,
  input  svgm_job_t          job,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               init_busy,
  input  wire logic          pop,
  output logic               empty,
  output logic [STATE_W-1:0] voxel_state,
  output logic [CNT_W-1:0]   changed_count,
  output logic               clipped
);

  localparam int XW    = $clog2(MAX_NX);
  localparam int YW    = $clog2(MAX_NY);
  localparam int ZW    = $clog2(MAX_NZ);
  localparam int AW    = XW + YW + ZW;
  localparam int DEPTH = 1 << AW;

  localparam logic [2:0] B_INIT  = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_CLR   = 3'd2;
  localparam logic [2:0] B_RD    = 3'd3;
  localparam logic [2:0] B_RDW   = 3'd4;
  localparam logic [2:0] B_WALK  = 3'd5;
  localparam logic [2:0] B_DRAIN = 3'd6;
  localparam logic [2:0] B_DONE  = 3'd7;

  logic [STATE_W-1:0]      mem [DEPTH];
  logic [STATE_W-1:0]      rdata;
  logic [2:0]              bstate;
  svgm_job_t               cur;
  logic [AW-1:0]           swp;
  logic [BOX_W-1:0]        ix, iy, iz;
  logic signed [OFS_W-1:0] ox, oy, oz, oy0, oz0;
  logic                    s1_v;
  logic [2*SQ_W-1:0]       s1_sqx, s1_sqy, s1_sqz;
  logic [AW-1:0]           s1_addr;
  logic [CNT_W-1:0]        cnt;
  logic [STATE_W-1:0]      rd_state;
  logic                    res_valid;

  logic [AW-1:0]           raddr, waddr, walk_addr, read_addr;
  logic                    we;
  logic [STATE_W-1:0]      wdata;
  logic                    is_walk;
  logic [STATE_W-1:0]      from_st, to_st;
  logic [2*SQ_W+1:0]       dsum;
  logic                    hit;
  logic                    in_range;
  logic                    z_last, y_last, x_last;
  logic signed [OFS_W-1:0] step2;

  assign init_busy = bstate == B_INIT;
  assign empty     = !res_valid;
  assign step2     = OFS_W'({cfg.spacing, 1'b0});
  assign is_walk   = (cur.req == REQ_ADD) || (cur.req == REQ_CARVE);
  assign from_st   = (cur.req == REQ_CARVE) ? VOX_OCC : VOX_EMPTY;
  assign to_st     = (cur.req == REQ_CARVE) ? VOX_SURF : VOX_OCC;
  assign walk_addr = {XW'(ix - BOX_W'(1)), YW'(iy - BOX_W'(1)), ZW'(iz - BOX_W'(1))};
  assign read_addr = {XW'(cur.vx), YW'(cur.vy), ZW'(cur.vz)};
  assign in_range  = (BOX_W'(cur.vx) < cfg.n_x) && (BOX_W'(cur.vy) < cfg.n_y)
                  && (BOX_W'(cur.vz) < cfg.n_z);
  assign z_last    = iz == cur.hi_z;
  assign y_last    = iy == cur.hi_y;
  assign x_last    = ix == cur.hi_x;
  assign dsum      = (2*SQ_W+2)'(s1_sqx) + (2*SQ_W+2)'(s1_sqy) + (2*SQ_W+2)'(s1_sqz);
  assign q_pop     = (bstate == B_IDLE) && !q_empty;

  always_comb begin
    if (is_walk) begin
      hit = s1_v && (rdata == from_st) && (dsum < (2*SQ_W+2)'(cur.lim));
    end else begin
      hit = s1_v && (rdata != VOX_EMPTY);
    end
  end

  always_comb begin
    case (bstate)
      B_INIT, B_CLR: begin
        raddr = swp;
        we    = 1'b1;
        waddr = swp;
        wdata = VOX_EMPTY;
      end
      B_RD: begin
        raddr = read_addr;
        we    = 1'b0;
        waddr = s1_addr;
        wdata = to_st;
      end
      default: begin
        raddr = walk_addr;
        we    = hit && is_walk;
        waddr = s1_addr;
        wdata = to_st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    s1_addr <= walk_addr;
    s1_sqx  <= sat_sq(ox);
    s1_sqy  <= sat_sq(oy);
    s1_sqz  <= sat_sq(oz);
    cnt     <= cnt + CNT_W'(hit);
    case (bstate)
      B_INIT: swp <= rst ? '0 : swp + AW'(1);
      B_CLR:  swp <= swp + AW'(1);
      B_IDLE: begin
        cur <= job;
        cnt <= '0;
        swp <= '0;
        ix  <= job.lo_x;
        iy  <= job.lo_y;
        iz  <= job.lo_z;
        ox  <= job.off_x;
        oy  <= job.off_y;
        oz  <= job.off_z;
        oy0 <= job.off_y;
        oz0 <= job.off_z;
      end
      B_RDW: rd_state <= in_range ? rdata : VOX_EMPTY;
      B_WALK: begin
        if (!z_last) begin
          iz <= iz + BOX_W'(1);
          oz <= oz + step2;
        end else begin
          iz <= cur.lo_z;
          oz <= oz0;
          if (!y_last) begin
            iy <= iy + BOX_W'(1);
            oy <= oy + step2;
          end else begin
            iy <= cur.lo_y;
            oy <= oy0;
            ix <= ix + BOX_W'(1);
            ox <= ox + step2;
          end
        end
      end
      default: ;
    endcase
    if (bstate == B_DONE && !res_valid) begin
      voxel_state   <= (cur.req == REQ_READ) ? rd_state : VOX_EMPTY;
      changed_count <= cnt;
      clipped       <= is_walk && cur.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_INIT;
      s1_v      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_v <= (bstate == B_WALK) || (bstate == B_CLR);
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end else if (bstate == B_DONE) begin
        res_valid <= 1'b1;
      end
      unique case (bstate)
        B_INIT: begin
          if (&swp) begin
            bstate <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            if (job.req == REQ_CLEAR) begin
              bstate <= B_CLR;
            end else if (job.req == REQ_READ) begin
              bstate <= B_RD;
            end else if (job.box_empty) begin
              bstate <= B_DONE;
            end else begin
              bstate <= B_WALK;
            end
          end
        end
        B_CLR: begin
          if (&swp) begin
            bstate <= B_DRAIN;
          end
        end
        B_RD:  bstate <= B_RDW;
        B_RDW: bstate <= B_DONE;
        B_WALK: begin
          if (x_last && y_last && z_last) begin
            bstate <= B_DRAIN;
          end
        end
        B_DRAIN: bstate <= B_DONE;
        B_DONE: begin
          if (!res_valid) begin
            bstate <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sim/sphere_voxel_grid_marker_unit_tb.sv
// Self-checking testbench for sphere_voxel_grid_marker_unit: random and directed
// requests against an in-bench voxel grid predictor. Depends on svgm_pkg and the RTL.
`timescale 1ns / 100ps

module sphere_voxel_grid_marker_unit_tb;
  import svgm_pkg::*;

  localparam int GRID_MAX = 64;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [REQ_W-1:0]          req;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic [PRB_W-1:0]          rad;
    logic [RSQ_W-1:0]          rsq;
    logic [VIX_W-1:0]          vx, vy, vz;
  } voxel_req_t;

  typedef struct {
    logic [STATE_W-1:0] vstate;
    logic [CNT_W-1:0]   cnt;
    logic               clip;
  } voxel_resp_t;

  logic clk, rst, push, full, empty, pop, clipped, cfg_valid, cfg_ready;
  logic [REQ_W-1:0] req_type;
  logic signed [COORD_W-1:0] center_x, center_y, center_z;
  logic [PRB_W-1:0] radius;
  logic [RSQ_W-1:0] radius_sq;
  logic [VIX_W-1:0] voxel_x, voxel_y, voxel_z;
  logic [STATE_W-1:0] voxel_state;
  logic [CNT_W-1:0] changed_count;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  voxel_req_t  pending_words[$];
  voxel_resp_t expected_results[$];
  logic [1:0]  grid_model[GRID_MAX][GRID_MAX][GRID_MAX];
  longint      org_x, org_y, org_z, spc_reg, probe_reg, nx_reg, ny_reg, nz_reg;
  int          mismatches, words_in, words_out, clip_seen;
  longint      cycles;
  bit          calm, word_taken;

  sphere_voxel_grid_marker_unit i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .radius(radius), .radius_sq(radius_sq), .voxel_x(voxel_x), .voxel_y(voxel_y),
    .voxel_z(voxel_z), .empty(empty), .pop(pop), .voxel_state(voxel_state),
    .changed_count(changed_count), .clipped(clipped), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint eff_spc();
    return (spc_reg == 0) ? 1 : spc_reg;
  endfunction

  function automatic longint eff_n(longint n);
    return (n > GRID_MAX) ? GRID_MAX : n;
  endfunction

  function automatic bit clamp_axis(longint c, longint r, longint org, longint n,
                                    output longint lo, output longint hi);
    longint s;
    bit clip;
    s = eff_spc();
    lo = (c - r - org + s) / s;
    hi = (c + r - org + s) / s;
    clip = 1'b0;
    if (lo < 1) begin
      lo = 1;
      clip = 1'b1;
    end
    if (hi > n) begin
      hi = n;
      clip = 1'b1;
    end
    return clip;
  endfunction

  function automatic voxel_resp_t sphere_mark(voxel_req_t w, longint r,
                                              longint unsigned lim, longint zsh,
                                              logic [1:0] from, logic [1:0] to);
    voxel_resp_t res;
    longint xl, xh, yl, yh, zl, zh, s, dx, dy, dz;
    longint unsigned dxy, n;
    res = '{default: '0};
    s = eff_spc();
    n = 0;
    res.clip = clamp_axis(w.cx, r, org_x, eff_n(nx_reg), xl, xh);
    res.clip |= clamp_axis(w.cy, r, org_y, eff_n(ny_reg), yl, yh);
    res.clip |= clamp_axis(w.cz, r, org_z, eff_n(nz_reg), zl, zh);
    for (longint ix = xl; ix <= xh; ix++) begin
      dx = s * (2 * ix - 1) + 2 * (org_x - w.cx);
      for (longint iy = yl; iy <= yh; iy++) begin
        dy = s * (2 * iy - 1) + 2 * (org_y - w.cy);
        dxy = dx * dx + dy * dy;
        if (lim > dxy) begin
          for (longint iz = zl; iz <= zh; iz++) begin
            dz = s * (2 * iz - 1 + zsh) + 2 * (org_z - w.cz);
            if (grid_model[ix-1][iy-1][iz-1] == from && lim > dxy + dz * dz) begin
              grid_model[ix-1][iy-1][iz-1] = to;
              n++;
            end
          end
        end
      end
    end
    res.cnt = n[CNT_W-1:0];
    return res;
  endfunction

  function automatic voxel_resp_t apply_request(voxel_req_t w);
    voxel_resp_t res;
    longint unsigned n;
    res = '{default: '0};
    case (w.req)
      REQ_CLEAR: begin
        n = 0;
        foreach (grid_model[i, j, k]) begin
          if (grid_model[i][j][k] != VOX_EMPTY) n++;
          grid_model[i][j][k] = VOX_EMPTY;
        end
        res.cnt = n[CNT_W-1:0];
      end
      REQ_ADD: res = sphere_mark(w, w.rad, 4 * longint'(w.rsq), 0, VOX_EMPTY, VOX_OCC);
      REQ_CARVE: res = sphere_mark(w, probe_reg, 4 * probe_reg * probe_reg, 2,
                                   VOX_OCC, VOX_SURF);
      default: begin
        if (w.vx < eff_n(nx_reg) && w.vy < eff_n(ny_reg) && w.vz < eff_n(nz_reg))
          res.vstate = grid_model[w.vx][w.vy][w.vz];
      end
    endcase
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    mismatches++;
    $display("mismatch on word %0d: %s got %0d expected %0d", words_out, what, got, want);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[sphere_voxel_grid_marker_unit] ERROR");
      $finish;
    end
    word_taken = push && !full;
    if (!rst && word_taken) begin
      expected_results.push_back(apply_request('{req_type, center_x, center_y, center_z,
                                                 radius, radius_sq, voxel_x, voxel_y,
                                                 voxel_z}));
      words_in++;
    end
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        voxel_resp_t e;
        e = expected_results.pop_front();
        if (voxel_state !== e.vstate) report("voxel_state", voxel_state, e.vstate);
        if (changed_count !== e.cnt) report("changed_count", changed_count, e.cnt);
        if (clipped !== e.clip) report("clipped", clipped, e.clip);
        clip_seen += e.clip;
      end
      words_out++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || word_taken) begin
      if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
        voxel_req_t w;
        w = pending_words.pop_front();
        req_type <= w.req;
        center_x <= w.cx;
        center_y <= w.cy;
        center_z <= w.cz;
        radius <= w.rad;
        radius_sq <= w.rsq;
        voxel_x <= w.vx;
        voxel_y <= w.vy;
        voxel_z <= w.vz;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
    pop <= calm || ($urandom_range(99) >= 25);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ORIGIN_X: org_x = longint'($signed(val));
      CFG_ORIGIN_Y: org_y = longint'($signed(val));
      CFG_ORIGIN_Z: org_z = longint'($signed(val));
      CFG_SPACING:  spc_reg = val[SPC_W-1:0];
      CFG_PROBE:    probe_reg = val[PRB_W-1:0];
      CFG_GRID_NX:  nx_reg = val[GN_W-1:0];
      CFG_GRID_NY:  ny_reg = val[GN_W-1:0];
      default:      nz_reg = val[GN_W-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(longint ox, longint oy, longint oz, longint sp, longint pr,
                          longint nx, longint ny, longint nz);
    write_reg(CFG_ORIGIN_X, ox[23:0]);
    write_reg(CFG_ORIGIN_Y, oy[23:0]);
    write_reg(CFG_ORIGIN_Z, oz[23:0]);
    write_reg(CFG_SPACING, sp[23:0]);
    write_reg(CFG_PROBE, pr[23:0]);
    write_reg(CFG_GRID_NX, nx[23:0]);
    write_reg(CFG_GRID_NY, ny[23:0]);
    write_reg(CFG_GRID_NZ, nz[23:0]);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic longint near_coord(longint org, longint n);
    longint s, ext, v;
    s = eff_spc();
    ext = ((eff_n(n) < 12) ? eff_n(n) : 12) * s;
    v = org - 2 * s + longint'($urandom_range(0, 32'(ext + 4 * s)));
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  function automatic voxel_req_t random_word(bit big_radius);
    voxel_req_t w;
    longint r, q;
    int pick;
    pick = $urandom_range(99);
    w.req = (pick < 45) ? REQ_ADD : (pick < 70) ? REQ_CARVE : REQ_READ;
    w.vx = VIX_W'($urandom);
    w.vy = VIX_W'($urandom);
    w.vz = VIX_W'($urandom);
    if ($urandom_range(9) == 0) begin
      w.cx = COORD_W'($urandom);
      w.cy = COORD_W'($urandom);
      w.cz = COORD_W'($urandom);
    end else begin
      w.cx = COORD_W'(near_coord(org_x, nx_reg));
      w.cy = COORD_W'(near_coord(org_y, ny_reg));
      w.cz = COORD_W'(near_coord(org_z, nz_reg));
    end
    r = $urandom_range(0, 32'(2 * eff_spc()));
    if (r > 4095) r = 4095;
    if (big_radius) r = $urandom_range(0, 4095);
    w.rad = PRB_W'(r);
    q = r * r + longint'($urandom_range(0, 32'(2 * r + 1))) - r;
    if (q < 0) q = 0;
    if (q > 16777215) q = 16777215;
    w.rsq = ($urandom_range(9) == 0) ? RSQ_W'($urandom) : q[RSQ_W-1:0];
    return w;
  endfunction

  task automatic random_phase(int count, bit big_radius);
    repeat (count) pending_words.push_back(random_word(big_radius));
    drain();
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_type = REQ_READ;
    {center_x, center_y, center_z, radius, radius_sq} = '0;
    {voxel_x, voxel_y, voxel_z} = '0;
    calm = 1'b0;
    foreach (grid_model[i, j, k]) grid_model[i][j][k] = VOX_EMPTY;
    org_x = 0; org_y = 0; org_z = 0;
    spc_reg = SPC_RST; probe_reg = PRB_RST;
    nx_reg = GN_RST; ny_reg = GN_RST; nz_reg = GN_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_grid(0, 0, 0, 128, 358, 64, 64, 64);
    pending_words.push_back('{REQ_ADD, 24'sd640, 24'sd640, 24'sd640, 12'd384, 24'd147456,
                              0, 0, 0});
    pending_words.push_back('{REQ_READ, 0, 0, 0, 0, 0, 6'd4, 6'd4, 6'd4});
    pending_words.push_back('{REQ_ADD, 24'sd1280, 24'sd640, 24'sd640, 12'd0, 24'd0,
                              0, 0, 0});
    pending_words.push_back('{REQ_ADD, 24'sd2000, 24'sd2000, 24'sd2000, 12'd4095,
                              24'hFFFFFF, 0, 0, 0});
    pending_words.push_back('{REQ_ADD, -24'sd8388608, 24'sd100, 24'sd100, 12'd200,
                              24'd40000, 0, 0, 0});
    pending_words.push_back('{REQ_ADD, 24'sd8388607, 24'sd8388607, 24'sd8388607, 12'd4095,
                              24'd1000, 0, 0, 0});
    pending_words.push_back('{REQ_ADD, 24'sd0, 24'sd0, 24'sd0, 12'd300, 24'd90000,
                              0, 0, 0});
    pending_words.push_back('{REQ_CARVE, 24'sd640, 24'sd640, 24'sd500, 0, 0, 0, 0, 0});
    pending_words.push_back('{REQ_CARVE, -24'sd8388608, -24'sd8388608, -24'sd8388608,
                              0, 0, 0, 0, 0});
    pending_words.push_back('{REQ_READ, 0, 0, 0, 0, 0, 6'd4, 6'd4, 6'd3});
    pending_words.push_back('{REQ_READ, 0, 0, 0, 0, 0, 6'd0, 6'd0, 6'd0});
    pending_words.push_back('{REQ_READ, 0, 0, 0, 0, 0, 6'd63, 6'd63, 6'd63});
    pending_words.push_back('{REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0});
    pending_words.push_back('{REQ_READ, 0, 0, 0, 0, 0, 6'd4, 6'd4, 6'd4});
    drain();
    random_phase(60, 1'b0);
    calm = 1'b1;
    random_phase(80, 1'b0);
    calm = 1'b0;
    random_phase(110, 1'b0);

    set_grid(-8388608, -8388608, -8388608, 1023, 4095, 8, 8, 8);
    random_phase(80, 1'b1);
    set_grid(8388607, 8388607, 8388607, 1, 0, 1, 1, 1);
    random_phase(40, 1'b1);
    set_grid(-300, 500, 0, 0, 2, 0, 0, 0);
    random_phase(30, 1'b1);
    set_grid(-1000, 2000, -3000, 200, 300, 100, 127, 70);
    random_phase(100, 1'b0);
    pending_words.push_back('{REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0});
    drain();
    set_grid(12345, -6789, 400, 64, 200, 20, 30, 10);
    random_phase(80, 1'b0);

    $display("%0d words sent, %0d results checked, %0d clipped boxes, 6 grid settings",
             words_in, words_out, clip_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[sphere_voxel_grid_marker_unit] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("[sphere_voxel_grid_marker_unit] ERROR");
    end
    $finish;
  end

endmodule
